### rtl/assert_macros.svh
// assertion macros used by the rtl mapper
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define SBSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// invariant checked on every rising edge outside reset
`define SBSM_ASSERT_ALWAYS(label, expr, msg) \
	`SBSM_ASSERT(label, (1'b1) |-> (expr), msg)

`endif

### rtl/sbsm_pkg.sv
// types and constants for the serial bank switch mapper
// no dependencies

package sbsm_pkg;

	localparam int unsigned ADDR_W      = 16;
	localparam int unsigned DATA_W      = 8;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned PRG_BANK_W  = 6;
	localparam int unsigned CHR_BANK_W  = 5;
	localparam int unsigned SHIFT_W     = 5;
	localparam int unsigned LOAD_CNT_W  = 3;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam int unsigned GATE_BIT    = 15;
	localparam int unsigned CLEAR_BIT   = 7;
	localparam int unsigned TGT_LSB     = 13;

	localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = COUNT_W'(16);
	localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = COUNT_W'(2);
	localparam logic [LOAD_CNT_W-1:0] LOAD_LAST    = LOAD_CNT_W'(SHIFT_W - 1);

	// control load bit positions
	localparam int unsigned CTL_MIRROR = 0;
	localparam int unsigned CTL_SWAP   = 2;
	localparam int unsigned CTL_SPLIT  = 3;
	localparam int unsigned CTL_CHR4K  = 4;

	typedef enum logic [1:0] {
		TGT_CONTROL  = 2'd0,
		TGT_CHR_LOW  = 2'd1,
		TGT_CHR_HIGH = 2'd2,
		TGT_PRG      = 2'd3
	} target_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRG_COUNT = 2'd0,
		CFG_CHR_COUNT = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic [PRG_BANK_W-1:0] prg_low;
		logic [PRG_BANK_W-1:0] prg_high;
		logic [CHR_BANK_W-1:0] chr_low;
		logic [CHR_BANK_W-1:0] chr_high;
		logic                  mirror_h;
	} map_t;

endpackage

### rtl/serial_bank_switch_mapper.sv
// serial bank switch mapper: input register, single-pass update, result register
// throughput: one write per cycle while the result is not stalled; the state update sits between the two registers
// reset: arst_n resets control state, maps the last program bank high, chr banks 0 and 1
// depends on sbsm_pkg and assert_macros.svh

`include "assert_macros.svh"

module serial_bank_switch_mapper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [sbsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbsm_pkg::COUNT_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sbsm_pkg::ADDR_W-1:0]    bus_address,
	input  logic [sbsm_pkg::DATA_W-1:0]    bus_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sbsm_pkg::PRG_BANK_W-1:0] prg_low_bank,
	output logic [sbsm_pkg::PRG_BANK_W-1:0] prg_high_bank,
	output logic [sbsm_pkg::CHR_BANK_W-1:0] chr_low_bank,
	output logic [sbsm_pkg::CHR_BANK_W-1:0] chr_high_bank,
	output logic                           horiz_mirror,
	output logic                           map_updated
);
	import sbsm_pkg::*;

	// input stage
	logic                  valid_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [DATA_W-1:0]     data_s1;

	// mapper state
	logic [COUNT_W-1:0]    prg_count_q;
	logic [COUNT_W-1:0]    chr_count_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic [LOAD_CNT_W-1:0] count_q;
	logic                  prg_whole_q;
	logic                  swap_low_q;
	logic                  chr_whole_q;
	map_t                  map_q;

	// result register
	logic                  out_valid_q;
	map_t                  out_map_q;
	logic                  out_updated_q;

	// next state
	logic                  advance;
	logic                  gated;
	logic                  clear_wr;
	logic                  load_done;
	logic [SHIFT_W-1:0]    shift_in;
	logic [SHIFT_W-1:0]    shift_n;
	logic [LOAD_CNT_W-1:0] count_n;
	logic                  prg_whole_n;
	logic                  swap_low_n;
	logic                  chr_whole_n;
	map_t                  map_n;
	target_t               target;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			addr_s1 <= bus_address;
			data_s1 <= bus_data;
		end
	end

	assign gated     = addr_s1[GATE_BIT];
	assign clear_wr  = data_s1[CLEAR_BIT];
	assign shift_in  = {data_s1[0], shift_q[SHIFT_W-1:1]};
	assign load_done = gated && !clear_wr && (count_q == LOAD_LAST);
	assign target    = target_t'(addr_s1[TGT_LSB +: 2]);

	always_comb begin
		shift_n     = shift_q;
		count_n     = count_q;
		prg_whole_n = prg_whole_q;
		swap_low_n  = swap_low_q;
		chr_whole_n = chr_whole_q;
		map_n       = map_q;
		if (gated) begin
			if (clear_wr) begin
				shift_n     = '0;
				count_n     = '0;
				swap_low_n  = 1'b1;
				prg_whole_n = 1'b0;
			end else if (!load_done) begin
				shift_n = shift_in;
				count_n = count_q + LOAD_CNT_W'(1);
			end else begin
				shift_n = '0;
				count_n = '0;
				unique case (target)
					TGT_CONTROL: begin
						map_n.mirror_h = shift_in[CTL_MIRROR];
						prg_whole_n    = !shift_in[CTL_SPLIT];
						if (shift_in[CTL_SPLIT]) begin
							swap_low_n = shift_in[CTL_SWAP];
						end
						chr_whole_n    = !shift_in[CTL_CHR4K];
					end
					TGT_CHR_LOW: begin
						if (chr_count_q != '0) begin
							if (chr_whole_q) begin
								map_n.chr_low  = {shift_in[SHIFT_W-1:1], 1'b0};
								map_n.chr_high = {shift_in[SHIFT_W-1:1], 1'b1};
							end else begin
								map_n.chr_low  = shift_in;
							end
						end
					end
					TGT_CHR_HIGH: begin
						if (chr_count_q != '0 && !chr_whole_q) begin
							map_n.chr_high = shift_in;
						end
					end
					TGT_PRG: begin
						// 32K mode pairs an even bank with the next one
						if (prg_whole_q) begin
							map_n.prg_low  = {shift_in, 1'b0};
							map_n.prg_high = {shift_in, 1'b1};
						end else if (swap_low_q) begin
							map_n.prg_low  = {1'b0, shift_in};
						end else begin
							map_n.prg_high = {1'b0, shift_in};
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q      <= PRG_COUNT_RESET;
			chr_count_q      <= CHR_COUNT_RESET;
			shift_q          <= '0;
			count_q          <= '0;
			prg_whole_q      <= 1'b0;
			swap_low_q       <= 1'b1;
			chr_whole_q      <= 1'b1;
			map_q.prg_low    <= '0;
			map_q.prg_high   <= PRG_COUNT_RESET - COUNT_W'(1);
			map_q.chr_low    <= '0;
			map_q.chr_high   <= CHR_BANK_W'(1);
			map_q.mirror_h   <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == CFG_PRG_COUNT) begin
				prg_count_q    <= cfg_data;
				map_q.prg_high <= cfg_data - COUNT_W'(1);
			end else if (cfg_index == CFG_CHR_COUNT) begin
				chr_count_q    <= cfg_data;
			end
		end else if (valid_s1 && advance) begin
			shift_q     <= shift_n;
			count_q     <= count_n;
			prg_whole_q <= prg_whole_n;
			swap_low_q  <= swap_low_n;
			chr_whole_q <= chr_whole_n;
			map_q       <= map_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_map_q     <= map_n;
			out_updated_q <= load_done;
		end
	end

	assign out_valid     = out_valid_q;
	assign prg_low_bank  = out_map_q.prg_low;
	assign prg_high_bank = out_map_q.prg_high;
	assign chr_low_bank  = out_map_q.chr_low;
	assign chr_high_bank = out_map_q.chr_high;
	assign horiz_mirror  = out_map_q.mirror_h;
	assign map_updated   = out_updated_q;

	`SBSM_ASSERT_ALWAYS(a_count_range, count_q <= LOAD_LAST, "load count past last bit")
	`SBSM_ASSERT(a_load_restarts, (valid_s1 && advance && load_done && !cfg_write) |=> (count_q == '0 && shift_q == '0), "completed load did not restart")
	`SBSM_ASSERT(a_stall_cause, in_stall |-> (out_valid_q && out_stall), "input stalled without a held result")
	`SBSM_ASSERT(a_s1_holds, (valid_s1 && !advance) |=> (valid_s1 && $stable(addr_s1) && $stable(data_s1)), "input stage lost a stalled write")

endmodule
